>>> hdl/ray_triangle_intersect_defines.svh
// assertion macros used by the ray triangle top level
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`ifndef SYNTHESIS
`define RTI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RTI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RTI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define RTI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/rti_pkg.sv
package rti_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int EPS_W          = 12;
  localparam int DIST_W         = 19;
  localparam int BARY_W         = 13;
  localparam int OUT_W          = 48;

  localparam logic [EPS_W-1:0]  EPS_RESET = 12'd1;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [BARY_W-1:0] BARY_MAX  = '1;

  typedef struct packed {
    logic              valid;
    logic              miss;
    logic [DIST_W-1:0] best;
  } ctl_t;

endpackage

>>> hdl/rti_front.sv
module rti_front import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CW = COORD_BITS,
  localparam int DW = CW + 1,
  localparam int XW = 2 * DW + 1 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic [3*CW-1:0]      origin,
  input  logic [3*CW-1:0]      direction,
  input  logic [3*CW-1:0]      va,
  input  logic [3*CW-1:0]      vb,
  input  logic [3*CW-1:0]      vc,
  output ctl_t                 ctl_out,
  output logic signed [DW-1:0] d_o  [3],
  output logic signed [DW-1:0] e1_o [3],
  output logic signed [DW-1:0] e2_o [3],
  output logic signed [DW-1:0] t_o  [3],
  output logic signed [XW-1:0] p_o  [3],
  output logic signed [XW-1:0] q_o  [3]
);

  ctl_t ctl1, ctl2;
  logic signed [DW-1:0] d1 [3], e11 [3], e21 [3], t1 [3];
  logic signed [DW-1:0] d2 [3], e12 [3], e22 [3], t2 [3];
  logic signed [2*DW-1:0] pa [3], pb [3], qa [3], qb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_axis
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      logic signed [2*DW:0] pdiff, qdiff, pshift, qshift;

      assign pdiff  = (2*DW+1)'(pa[k]) - (2*DW+1)'(pb[k]);
      assign qdiff  = (2*DW+1)'(qa[k]) - (2*DW+1)'(qb[k]);
      assign pshift = pdiff >>> FRAC_BITS;
      assign qshift = qdiff >>> FRAC_BITS;

      always_ff @(posedge clk) begin
        if (en) begin
          // edges and origin offset
          d1[k]  <= DW'($signed(direction[k*CW +: CW]));
          e11[k] <= DW'($signed(vb[k*CW +: CW])) - DW'($signed(va[k*CW +: CW]));
          e21[k] <= DW'($signed(vc[k*CW +: CW])) - DW'($signed(va[k*CW +: CW]));
          t1[k]  <= DW'($signed(origin[k*CW +: CW])) - DW'($signed(va[k*CW +: CW]));
          // cross product terms, p = d x e2, q = t x e1
          pa[k]  <= d1[K1] * e21[K2];
          pb[k]  <= d1[K2] * e21[K1];
          qa[k]  <= t1[K1] * e11[K2];
          qb[k]  <= t1[K2] * e11[K1];
          d2[k]  <= d1[k];
          e12[k] <= e11[k];
          e22[k] <= e21[k];
          t2[k]  <= t1[k];
          // floor back to the coordinate scale
          p_o[k]  <= pshift[XW-1:0];
          q_o[k]  <= qshift[XW-1:0];
          d_o[k]  <= d2[k];
          e1_o[k] <= e12[k];
          e2_o[k] <= e22[k];
          t_o[k]  <= t2[k];
        end
      end
    end
  endgenerate

endmodule

>>> hdl/rti_dot.sv
module rti_dot import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int XW = 2 * DW + 1 - FRAC_BITS,
  localparam int MW = DW + XW,
  localparam int NW = MW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [EPS_W-1:0]     eps,
  input  ctl_t                 ctl_in,
  input  logic signed [DW-1:0] d  [3],
  input  logic signed [DW-1:0] e1 [3],
  input  logic signed [DW-1:0] e2 [3],
  input  logic signed [DW-1:0] t  [3],
  input  logic signed [XW-1:0] p  [3],
  input  logic signed [XW-1:0] q  [3],
  output ctl_t                 ctl_out,
  output logic [NW-1:0]        den,
  output logic [NW-1:0]        num_u,
  output logic [NW-1:0]        num_v,
  output logic [NW-1:0]        num_t
);

  ctl_t ctl4, ctl5;
  logic signed [MW-1:0] m_det [3], m_u [3], m_v [3], m_t [3];
  logic signed [NW-1:0] det, un, vn, tn, eps_s;
  logic signed [NW:0]   uv;
  logic                 reject;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4    <= '0;
      ctl5    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl4    <= ctl_in;
      ctl5    <= ctl4;
      ctl_out <= '{valid: ctl5.valid, miss: ctl5.miss | reject, best: ctl5.best};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_det[k] <= e1[k] * p[k];
        m_u[k]   <= t[k] * p[k];
        m_v[k]   <= d[k] * q[k];
        m_t[k]   <= e2[k] * q[k];
      end
      det   <= NW'(m_det[0]) + NW'(m_det[1]) + NW'(m_det[2]);
      un    <= NW'(m_u[0]) + NW'(m_u[1]) + NW'(m_u[2]);
      vn    <= NW'(m_v[0]) + NW'(m_v[1]) + NW'(m_v[2]);
      tn    <= NW'(m_t[0]) + NW'(m_t[1]) + NW'(m_t[2]);
      den   <= det;
      num_u <= un;
      num_v <= vn;
      num_t <= tn;
    end
  end

  assign eps_s = NW'(eps) << FRAC_BITS;
  assign uv    = (NW+1)'(un) + (NW+1)'(vn);

  // back face, determinant below epsilon, outside the triangle or behind the origin
  assign reject = (det < eps_s) || (det <= 0) || (un < 0) || (un > det) || (vn < 0)
               || (uv > (NW+1)'(det)) || (tn < 0);

endmodule

>>> hdl/rti_div.sv
module rti_div import rti_pkg::*; #(
  parameter int NW        = 54,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int SH = DIST_W - FRAC_BITS,
  localparam int RW = NW + 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     num,
  input  logic [NW-1:0]     den,
  output logic [DIST_W-1:0] quo
);

  logic [RW-1:0]     rem [DIST_W+1];
  logic [NW-1:0]     dv  [DIST_W+1];
  logic [SH-1:0]     lo  [DIST_W+1];
  logic [DIST_W-1:0] qb  [DIST_W+1];
  logic              sat [DIST_W+1];

  // quotient needs more than DIST_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= ({{SH{1'b0}}, num} >= {den, {SH{1'b0}}});
      rem[0] <= RW'(num >> SH);
      dv[0]  <= den;
      lo[0]  <= num[SH-1:0];
      qb[0]  <= '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < DIST_W; k++) begin : g_step
      logic          inbit;
      logic [RW-1:0] shifted;
      logic          ge;

      if (k < SH) begin : g_num
        assign inbit = lo[k][SH-1];
      end else begin : g_zero
        assign inbit = 1'b0;
      end

      assign shifted = {rem[k][NW-1:0], inbit};
      assign ge      = shifted >= {1'b0, dv[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? shifted - {1'b0, dv[k]} : shifted;
          dv[k+1]  <= dv[k];
          lo[k+1]  <= lo[k] << 1;
          qb[k+1]  <= {qb[k][DIST_W-2:0], ge};
          sat[k+1] <= sat[k];
        end
      end
    end
  endgenerate

  assign quo = sat[DIST_W] ? DIST_MAX : qb[DIST_W];

endmodule

>>> hdl/ray_triangle_intersect.sv
// ray/triangle intersection, back faces culled, one per clock if no stall
//
// s_axis carries one test per word: ray origin, ray direction, the three
// triangle vertices and the nearest distance found so far. m_axis returns
// one result word per test: hit flag, new nearest distance and the two
// barycentric coordinates of the hit (zero on a miss).
// cfg_valid/cfg_data write the epsilon register; cfg_ready is always high.
// epsilon bounds both the determinant and the hit distance from below.
//
// pipeline: three stages form edges and cross products, three form dot
// products and the reject tests, the divider registers its inputs and then
// adds one quotient bit per stage, and one output register ends the chain.
// a new test is accepted every cycle while m_axis_tready is high.
// when m_axis holds a word that is not taken the whole pipeline freezes and
// s_axis_tready drops; no word is lost or repeated.
// reset empties the pipeline and sets epsilon to one lsb.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int VW   = 3 * COORD_BITS,
  localparam int IN_W = ((5 * VW + DIST_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c, best_distance
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit, new_distance, bary_u, bary_v
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [EPS_W-1:0] cfg_data
);

`include "ray_triangle_intersect_defines.svh"

  localparam int DW  = COORD_BITS + 1;
  localparam int XW  = 2 * DW + 1 - FRAC_BITS;
  localparam int NW  = DW + XW + 2;
  localparam int LAT = DIST_W + 1;

  logic [EPS_W-1:0] eps;
  logic             en;
  ctl_t             in_ctl, f_ctl, dot_ctl, tail;
  ctl_t             ctl_dv [LAT];

  logic signed [DW-1:0] d [3], e1 [3], e2 [3], t [3];
  logic signed [XW-1:0] p [3], q [3];
  logic [NW-1:0]        den, num_u, num_v, num_t;
  logic [DIST_W-1:0]    qt, qu, qv;

  logic              out_valid, hit_r;
  logic [DIST_W-1:0] dist_r;
  logic [BARY_W-1:0] u_r, v_r;
  logic              hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_valid) begin
      eps <= cfg_data;
    end
  end

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign in_ctl        = '{valid: s_axis_tvalid, miss: 1'b0,
                           best: s_axis_tdata[5*VW +: DIST_W]};

  rti_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (in_ctl),
    .origin    (s_axis_tdata[0 +: VW]),
    .direction (s_axis_tdata[VW +: VW]),
    .va        (s_axis_tdata[2*VW +: VW]),
    .vb        (s_axis_tdata[3*VW +: VW]),
    .vc        (s_axis_tdata[4*VW +: VW]),
    .ctl_out   (f_ctl),
    .d_o       (d),
    .e1_o      (e1),
    .e2_o      (e2),
    .t_o       (t),
    .p_o       (p),
    .q_o       (q)
  );

  rti_dot #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dot (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .eps     (eps),
    .ctl_in  (f_ctl),
    .d       (d),
    .e1      (e1),
    .e2      (e2),
    .t       (t),
    .p       (p),
    .q       (q),
    .ctl_out (dot_ctl),
    .den     (den),
    .num_u   (num_u),
    .num_v   (num_v),
    .num_t   (num_t)
  );

  rti_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_t (
    .clk (clk), .en (en), .num (num_t), .den (den), .quo (qt)
  );

  rti_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk (clk), .en (en), .num (num_u), .den (den), .quo (qu)
  );

  rti_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk (clk), .en (en), .num (num_v), .den (den), .quo (qv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        ctl_dv[i] <= '0;
      end
    end else if (en) begin
      ctl_dv[0] <= dot_ctl;
      for (int i = 1; i < LAT; i++) begin
        ctl_dv[i] <= ctl_dv[i-1];
      end
    end
  end

  assign tail = ctl_dv[LAT-1];
  assign hit  = !tail.miss && (qt >= DIST_W'(eps)) && (qt <= tail.best);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit;
      dist_r <= hit ? qt : tail.best;
      u_r    <= !hit ? '0 : (qu > DIST_W'(BARY_MAX)) ? BARY_MAX : qu[BARY_W-1:0];
      v_r    <= !hit ? '0 : (qv > DIST_W'(BARY_MAX)) ? BARY_MAX : qv[BARY_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - 1 - DIST_W - 2*BARY_W){1'b0}}, v_r, u_r, dist_r, hit_r};

  `RTI_ASSERT_IMPLY(a_miss_bary_zero, clk, rst, out_valid && !hit_r, (u_r == '0) && (v_r == '0), "barycentrics set on a miss")
  `RTI_ASSERT_IMPLY(a_hit_dist_min, clk, rst, out_valid && hit_r, dist_r >= DIST_W'(eps), "hit closer than epsilon")
  `RTI_ASSERT_IMPLY(a_hit_bary_sum, clk, rst, out_valid && hit_r, (32'(u_r) + 32'(v_r)) <= (32'd1 << FRAC_BITS), "barycentric sum above one")
  `RTI_ASSERT_NEXT(a_tail_to_out, clk, rst, en && tail.valid, out_valid, "result dropped at output register")

endmodule
